// ----- design/rpcf_pkg.sv -----
// shared types, constants and channel functions for the rgb pixel color filter
package rpcf_pkg;

   localparam int MAX_LINE_WIDTH = 4096;
   localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
   localparam int LW_W           = COL_W + 1;
   localparam int MODE_W         = 5;
   localparam int SAMPLE_W       = 8;
   localparam int CSR_ADDR_W     = 4;
   localparam int CSR_DATA_W     = 32;
   localparam int SUM_W          = SAMPLE_W + 2;
   localparam int RECIP_W        = 10;
   localparam int PROD_W         = SUM_W + RECIP_W + 1;

   // x / 3 == (x * 683) >> 11 for every three-sample sum
   localparam logic [RECIP_W-1:0] RECIP_THIRD = RECIP_W'(683);
   localparam int                 RECIP_SHIFT = 11;

   localparam logic [LW_W-1:0] LW_MAX   = LW_W'(MAX_LINE_WIDTH);
   localparam logic [LW_W-1:0] LW_ONE   = LW_W'(1);
   localparam logic [LW_W-1:0] LW_ZERO  = LW_W'(0);

   // register indexes
   localparam logic [1:0] REG_FILTER_MODE = 2'd0;
   localparam logic [1:0] REG_MAX_VALUE   = 2'd1;
   localparam logic [1:0] REG_LINE_WIDTH  = 2'd2;

   localparam logic [MODE_W-1:0]   RESET_FILTER_MODE = MODE_W'(0);
   localparam logic [SAMPLE_W-1:0] RESET_MAX_VALUE   = SAMPLE_W'(255);
   localparam logic [LW_W-1:0]     RESET_LINE_WIDTH  = LW_W'(640);

   typedef enum logic [2:0] {
      OP_PASS,
      OP_GREY,
      OP_INV,
      OP_COL,
      OP_ZERO
   } op_type;

   typedef struct packed {
      logic [MODE_W-1:0]   filter_mode;
      logic [SAMPLE_W-1:0] max_value;
      logic [LW_W-1:0]     line_width;
   } cfg_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] red;
      logic [SAMPLE_W-1:0] green;
      logic [SAMPLE_W-1:0] blue;
      logic [COL_W-1:0]    col;
   } pix_type;

   typedef struct packed {
      op_type red;
      op_type green;
      op_type blue;
   } op_set_type;

   // per-channel operation for each mode, modes zero, eight and above twenty pass through
   function automatic op_set_type mode_ops(input logic [MODE_W-1:0] mode);
      op_set_type ops;
      case (mode)
         5'd1:    ops = '{OP_GREY, OP_GREY, OP_GREY};
         5'd2:    ops = '{OP_PASS, OP_GREY, OP_GREY};
         5'd3:    ops = '{OP_PASS, OP_PASS, OP_GREY};
         5'd4:    ops = '{OP_GREY, OP_PASS, OP_PASS};
         5'd5:    ops = '{OP_PASS, OP_GREY, OP_PASS};
         5'd6:    ops = '{OP_GREY, OP_GREY, OP_PASS};
         5'd7:    ops = '{OP_INV,  OP_INV,  OP_INV };
         5'd9:    ops = '{OP_COL,  OP_PASS, OP_COL };
         5'd10:   ops = '{OP_PASS, OP_COL,  OP_COL };
         5'd11:   ops = '{OP_PASS, OP_PASS, OP_COL };
         5'd12:   ops = '{OP_COL,  OP_PASS, OP_PASS};
         5'd13:   ops = '{OP_COL,  OP_COL,  OP_PASS};
         5'd14:   ops = '{OP_PASS, OP_COL,  OP_PASS};
         5'd15:   ops = '{OP_ZERO, OP_PASS, OP_PASS};
         5'd16:   ops = '{OP_ZERO, OP_ZERO, OP_PASS};
         5'd17:   ops = '{OP_ZERO, OP_PASS, OP_ZERO};
         5'd18:   ops = '{OP_PASS, OP_ZERO, OP_ZERO};
         5'd19:   ops = '{OP_PASS, OP_PASS, OP_ZERO};
         5'd20:   ops = '{OP_PASS, OP_ZERO, OP_PASS};
         default: ops = '{OP_PASS, OP_PASS, OP_PASS};
      endcase
      return ops;
   endfunction

   function automatic logic [SAMPLE_W-1:0] chan_result(
      input op_type              op,
      input logic [SAMPLE_W-1:0] sample,
      input logic [SAMPLE_W-1:0] grey,
      input logic [SAMPLE_W-1:0] col,
      input logic [SAMPLE_W-1:0] max_value
   );
      logic [SAMPLE_W-1:0] res;
      case (op)
         OP_GREY: res = grey;
         OP_INV:  res = max_value - sample;
         OP_COL:  res = col;
         OP_ZERO: res = '0;
         default: res = sample;
      endcase
      return res;
   endfunction

endpackage

// ----- design/rpcf_csr.sv -----
// apb register file for filter mode, max value and line width
module rpcf_csr
   import rpcf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_FILTER_MODE: cfg_in.filter_mode = csr_pwdata[MODE_W-1:0];
            REG_MAX_VALUE:   cfg_in.max_value   = csr_pwdata[SAMPLE_W-1:0];
            REG_LINE_WIDTH:  cfg_in.line_width  = csr_pwdata[LW_W-1:0];
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.filter_mode <= RESET_FILTER_MODE;
         cfg_ff.max_value   <= RESET_MAX_VALUE;
         cfg_ff.line_width  <= RESET_LINE_WIDTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_FILTER_MODE: csr_prdata = CSR_DATA_W'(cfg_ff.filter_mode);
         REG_MAX_VALUE:   csr_prdata = CSR_DATA_W'(cfg_ff.max_value);
         REG_LINE_WIDTH:  csr_prdata = CSR_DATA_W'(cfg_ff.line_width);
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/rpcf_in_stage.sv -----
// input register with the column tracker
module rpcf_in_stage
   import rpcf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [3*SAMPLE_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  cfg_type               cfg,
   input  logic                  down_ready,
   output logic                  pix_valid,
   output pix_type               pix
);

   logic             valid_ff, valid_in;
   pix_type          pix_ff, pix_in;
   logic [COL_W-1:0] column_ff, column_in;
   logic [LW_W-1:0]  eff_width;
   logic [LW_W-1:0]  col_next;
   logic [COL_W-1:0] col_now;
   logic             accept;

   assign req_tready = !valid_ff || down_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (cfg.line_width == LW_ZERO) begin
         eff_width = LW_ONE;
      end else if (cfg.line_width > LW_MAX) begin
         eff_width = LW_MAX;
      end else begin
         eff_width = cfg.line_width;
      end
   end

   always_comb begin
      // a stored column past a narrowed line counts as column zero
      if (req_tuser || {1'b0, column_ff} >= eff_width) begin
         col_now = '0;
      end else begin
         col_now = column_ff;
      end
      col_next = {1'b0, col_now} + LW_ONE;
      if (col_next >= eff_width) begin
         column_in = '0;
      end else begin
         column_in = col_next[COL_W-1:0];
      end
   end

   always_comb begin
      pix_in.red   = req_tdata[SAMPLE_W-1:0];
      pix_in.green = req_tdata[2*SAMPLE_W-1:SAMPLE_W];
      pix_in.blue  = req_tdata[3*SAMPLE_W-1:2*SAMPLE_W];
      pix_in.col   = col_now;
      valid_in     = accept || (valid_ff && !down_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         column_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (accept) begin
            column_ff <= column_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff <= pix_in;
      end
   end

   assign pix_valid = valid_ff;
   assign pix       = pix_ff;

`ifndef ASSERT_OFF
   a_frame_start_col_zero: assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser |=> pix_ff.col == '0)
      else $error("frame start item did not get column zero");

   a_stalled_item_held: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !down_ready |=> valid_ff)
      else $error("stalled item dropped from input register");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> valid_ff)
      else $error("accepted item not in input register");
`endif

endmodule

// ----- design/rpcf_filter_stage.sv -----
// grey average, per-channel operation select and result register
module rpcf_filter_stage
   import rpcf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pix_valid,
   input  pix_type               pix,
   input  cfg_type               cfg,
   output logic                  up_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [3*SAMPLE_W-1:0] rsp_tdata
);

   logic                  valid_ff, valid_in;
   logic [3*SAMPLE_W-1:0] data_ff, data_in;
   logic [SUM_W-1:0]      sum;
   logic [PROD_W-1:0]     prod;
   logic [SAMPLE_W-1:0]   grey;
   logic [SAMPLE_W-1:0]   col8;
   op_set_type            ops;
   logic                  load;

   assign up_ready = !valid_ff || rsp_tready;
   assign load     = pix_valid && up_ready;

   always_comb begin
      sum  = SUM_W'(pix.red) + SUM_W'(pix.green) + SUM_W'(pix.blue);
      prod = PROD_W'(sum) * PROD_W'(RECIP_THIRD);
      grey = prod[RECIP_SHIFT +: SAMPLE_W];
      col8 = pix.col[SAMPLE_W-1:0];
      ops  = mode_ops(cfg.filter_mode);
      data_in = {chan_result(ops.blue,  pix.blue,  grey, col8, cfg.max_value),
                 chan_result(ops.green, pix.green, grey, col8, cfg.max_value),
                 chan_result(ops.red,   pix.red,   grey, col8, cfg.max_value)};
      valid_in = load || (valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

`ifndef ASSERT_OFF
   a_load_fills: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded item missing from result register");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_tready |=> valid_ff && $stable(data_ff))
      else $error("result register changed while stalled");

   a_idle_empties: assert property (@(posedge clock) disable iff (reset)
      valid_ff && rsp_tready && !pix_valid |=> !valid_ff)
      else $error("result repeated after it was taken");
`endif

endmodule

// ----- design/rgb_pixel_color_filter_top.sv -----
// top level of the rgb pixel color filter
//
//   channel  dir  handshake            payload
//   req      in   req_tvalid/tready    tdata red,green,blue; tuser frame_start
//   rsp      out  rsp_tvalid/tready    tdata red,green,blue
//   csr      in   apb psel/penable     filter_mode @0, max_value @4, line_width @8
//
// one item per clock when the result side keeps up; an accepted item passes through
// the input register, then the result register, before it appears at rsp
// reset is synchronous and active high; it empties both registers, zeroes the
// column and loads the register reset values
// a stall on rsp holds both registers and lowers req_tready once both are full
module rgb_pixel_color_filter_top
   import rpcf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [3*SAMPLE_W-1:0] req_tdata,  // red_in, green_in, blue_in
   input  logic                  req_tuser,  // frame_start
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [3*SAMPLE_W-1:0] rsp_tdata,  // red_out, green_out, blue_out
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;
   pix_type pix;
   logic    pix_valid;
   logic    filt_ready;

   rpcf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rpcf_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg),
      .down_ready (filt_ready),
      .pix_valid  (pix_valid),
      .pix        (pix)
   );

   rpcf_filter_stage u_filter_stage (
      .clock      (clock),
      .reset      (reset),
      .pix_valid  (pix_valid),
      .pix        (pix),
      .cfg        (cfg),
      .up_ready   (filt_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
